[rtl/spwfc_pkg.sv]
// Package for the motor speed PID block: stage payload types, register
// indexes, feedback identifier window and register reset values.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spwfc_pkg;

	localparam logic [10:0] FEEDBACK_ID_LOW  = 11'h201;
	localparam logic [10:0] FEEDBACK_ID_HIGH = 11'h208;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TARGET_SPEED      = 3'd0,
		REG_PROPORTIONAL_GAIN = 3'd1,
		REG_INTEGRAL_GAIN     = 3'd2,
		REG_DERIVATIVE_GAIN   = 3'd3,
		REG_INTEGRAL_LIMIT    = 3'd4,
		REG_OUTPUT_LIMIT      = 3'd5
	} cfg_reg_t;

	localparam logic [14:0] TARGET_SPEED_RESET      = 15'd500;
	localparam logic [15:0] PROPORTIONAL_GAIN_RESET = 16'd768;
	localparam logic [15:0] INTEGRAL_GAIN_RESET     = 16'd26;
	localparam logic [15:0] DERIVATIVE_GAIN_RESET   = 16'd0;
	localparam logic [14:0] INTEGRAL_LIMIT_RESET    = 15'd1000;
	localparam logic [14:0] OUTPUT_LIMIT_RESET      = 15'd10000;

	// Error terms of one tick, handed from the error stage to the multipliers.
	typedef struct packed {
		logic               online;
		logic signed [15:0] err;
		logic signed [15:0] sum;
		logic signed [16:0] diff;
	} err_terms_t;

	// Load strobes for the product and result registers.
	typedef struct packed {
		logic load_s3;
		logic load_out;
	} mac_ctrl_t;

endpackage

`default_nettype wire

[rtl/spwfc_err.sv]
// Error stage: holds the captured speed, online flag, integral and previous
// error, and forms the saturated error, clamped integral and derivative.
// Depends on spwfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spwfc_err
	import spwfc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              operation,
	input  wire logic [10:0]       frame_id,
	input  wire logic [7:0]        speed_high_byte,
	input  wire logic [7:0]        speed_low_byte,
	input  wire logic [14:0]       target_speed,
	input  wire logic [14:0]       integral_limit,
	output      logic              feedback_seen,
	output      err_terms_t        terms_s2
);

	logic signed [15:0] measured_speed_q;
	logic               feedback_seen_q;
	logic signed [15:0] error_sum_q;
	logic signed [15:0] previous_error_q;

	logic signed [16:0] raw_err;
	logic signed [15:0] err;
	logic signed [16:0] raw_sum;
	logic signed [16:0] lim17;
	logic signed [15:0] sum;
	logic signed [16:0] diff;
	logic               id_ok;

	assign id_ok = (frame_id >= FEEDBACK_ID_LOW) && (frame_id <= FEEDBACK_ID_HIGH);

	always_comb begin
		raw_err = $signed({{2{target_speed[14]}}, target_speed})
			- $signed({measured_speed_q[15], measured_speed_q});
		if (raw_err > 17'sd32767) begin
			err = 16'sh7FFF;
		end else if (raw_err < -17'sd32768) begin
			err = 16'sh8000;
		end else begin
			err = raw_err[15:0];
		end
		raw_sum = $signed({error_sum_q[15], error_sum_q}) + $signed({err[15], err});
		lim17   = $signed({2'b00, integral_limit});
		if (raw_sum > lim17) begin
			sum = lim17[15:0];
		end else if (raw_sum < -lim17) begin
			sum = 16'(-lim17);
		end else begin
			sum = raw_sum[15:0];
		end
		diff = $signed({err[15], err}) - $signed({previous_error_q[15], previous_error_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measured_speed_q <= '0;
			feedback_seen_q  <= 1'b0;
			error_sum_q      <= '0;
			previous_error_q <= '0;
		end else if (step) begin
			if (!operation) begin
				if (id_ok) begin
					measured_speed_q <= {speed_high_byte, speed_low_byte};
					feedback_seen_q  <= 1'b1;
				end
			end else if (feedback_seen_q) begin
				error_sum_q      <= sum;
				previous_error_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && operation) begin
			terms_s2.online <= feedback_seen_q;
			terms_s2.err    <= err;
			terms_s2.sum    <= sum;
			terms_s2.diff   <= diff;
		end
	end

	assign feedback_seen = feedback_seen_q;

endmodule

`default_nettype wire

[rtl/spwfc_mac.sv]
// Gain stage: registers the three gain products, then adds them, scales
// with truncation toward zero, clamps to the output limit; zero when offline.
// Depends on spwfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spwfc_mac
	import spwfc_pkg::*;
#(
	parameter int GAIN_FRACTION_BITS = 8
) (
	input  wire logic               clk,
	input  wire mac_ctrl_t          ctrl,
	input  wire err_terms_t         terms_s2,
	input  wire logic signed [15:0] proportional_gain,
	input  wire logic signed [15:0] integral_gain,
	input  wire logic signed [15:0] derivative_gain,
	input  wire logic [14:0]        output_limit,
	output      logic signed [15:0] drive_current,
	output      logic               online
);

	localparam int ACC_W = 35;
	localparam logic signed [ACC_W-1:0] ROUND_BIAS =
		(ACC_W'(1) <<< GAIN_FRACTION_BITS) - ACC_W'(1);

	logic signed [31:0] p_prod;
	logic signed [31:0] i_prod;
	logic signed [32:0] d_prod;
	logic signed [31:0] p_s3;
	logic signed [31:0] i_s3;
	logic signed [32:0] d_s3;
	logic               online_s3;

	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] biased;
	logic signed [ACC_W-1:0] scaled;
	logic signed [ACC_W-1:0] lim;
	logic signed [15:0]      clamped;

	assign p_prod = proportional_gain * terms_s2.err;
	assign i_prod = integral_gain * terms_s2.sum;
	assign d_prod = derivative_gain * terms_s2.diff;

	always_ff @(posedge clk) begin
		if (ctrl.load_s3) begin
			p_s3      <= p_prod;
			i_s3      <= i_prod;
			d_s3      <= d_prod;
			online_s3 <= terms_s2.online;
		end
	end

	always_comb begin
		acc    = ACC_W'(p_s3) + ACC_W'(i_s3) + ACC_W'(d_s3);
		biased = acc[ACC_W-1] ? acc + ROUND_BIAS : acc;
		scaled = biased >>> GAIN_FRACTION_BITS;
		lim    = $signed({{(ACC_W-15){1'b0}}, output_limit});
		if (scaled > lim) begin
			clamped = lim[15:0];
		end else if (scaled < -lim) begin
			clamped = 16'(-lim);
		end else begin
			clamped = scaled[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			drive_current <= online_s3 ? clamped : 16'sd0;
			online        <= online_s3;
		end
	end

endmodule

`default_nettype wire

[rtl/speed_pid_with_feedback_capture.sv]
// Top level of the motor speed PID with feedback capture: ports, register
// file, input register and stage handshakes. Instantiates spwfc_err and
// spwfc_mac; depends on spwfc_pkg.
//
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_ready    operation, frame_id, speed bytes
// out      source     out_valid / out_ready  drive_current, online
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat is accepted per cycle while in_ready is high. A tick passes the
// input register, error stage, product register and output register in turn.
// A feedback beat ends in the error stage and gives no result.
// Each stage moves on when the stage after it is empty or moving, so a stall
// at out_ready fills the pipeline before in_ready drops.
// Reset clears the valid bits and the controller state and loads the
// register defaults; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module speed_pid_with_feedback_capture
	import spwfc_pkg::*;
#(
	parameter int GAIN_FRACTION_BITS = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output      logic                   in_ready,
	input  wire logic                   operation,
	input  wire logic [10:0]            frame_id,
	input  wire logic [7:0]             speed_high_byte,
	input  wire logic [7:0]             speed_low_byte,
	output      logic                   out_valid,
	input  wire logic                   out_ready,
	output      logic signed [15:0]     drive_current,
	output      logic                   online,
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [14:0]        target_speed_q;
	logic signed [15:0] proportional_gain_q;
	logic signed [15:0] integral_gain_q;
	logic signed [15:0] derivative_gain_q;
	logic [14:0]        integral_limit_q;
	logic [14:0]        output_limit_q;

	logic        v_s1;
	logic        operation_s1;
	logic [10:0] frame_id_s1;
	logic [7:0]  speed_high_byte_s1;
	logic [7:0]  speed_low_byte_s1;
	logic        v_s2;
	logic        v_s3;
	logic        out_valid_q;

	logic       go1;
	logic       go2;
	logic       go3;
	logic       free2;
	logic       free3;
	logic       out_free;
	logic       feedback_seen;
	err_terms_t terms_s2;
	mac_ctrl_t  mac_ctrl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_speed_q      <= TARGET_SPEED_RESET;
			proportional_gain_q <= PROPORTIONAL_GAIN_RESET;
			integral_gain_q     <= INTEGRAL_GAIN_RESET;
			derivative_gain_q   <= DERIVATIVE_GAIN_RESET;
			integral_limit_q    <= INTEGRAL_LIMIT_RESET;
			output_limit_q      <= OUTPUT_LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_TARGET_SPEED:      target_speed_q      <= cfg_data[14:0];
				REG_PROPORTIONAL_GAIN: proportional_gain_q <= cfg_data;
				REG_INTEGRAL_GAIN:     integral_gain_q     <= cfg_data;
				REG_DERIVATIVE_GAIN:   derivative_gain_q   <= cfg_data;
				REG_INTEGRAL_LIMIT:    integral_limit_q    <= cfg_data[14:0];
				REG_OUTPUT_LIMIT:      output_limit_q      <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign go3      = v_s3 && out_free;
	assign free3    = !v_s3 || go3;
	assign go2      = v_s2 && free3;
	assign free2    = !v_s2 || go2;
	assign go1      = v_s1 && (!operation_s1 || free2);
	assign in_ready = !v_s1 || go1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (free2) begin
				v_s2 <= go1 && operation_s1;
			end
			if (free3) begin
				v_s3 <= go2;
			end
			if (out_free) begin
				out_valid_q <= go3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			operation_s1       <= operation;
			frame_id_s1        <= frame_id;
			speed_high_byte_s1 <= speed_high_byte;
			speed_low_byte_s1  <= speed_low_byte;
		end
	end

	spwfc_err u_err (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (go1),
		.operation       (operation_s1),
		.frame_id        (frame_id_s1),
		.speed_high_byte (speed_high_byte_s1),
		.speed_low_byte  (speed_low_byte_s1),
		.target_speed    (target_speed_q),
		.integral_limit  (integral_limit_q),
		.feedback_seen   (feedback_seen),
		.terms_s2        (terms_s2)
	);

	assign mac_ctrl.load_s3  = go2;
	assign mac_ctrl.load_out = go3;

	spwfc_mac #(
		.GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
	) u_mac (
		.clk               (clk),
		.ctrl              (mac_ctrl),
		.terms_s2          (terms_s2),
		.proportional_gain (proportional_gain_q),
		.integral_gain     (integral_gain_q),
		.derivative_gain   (derivative_gain_q),
		.output_limit      (output_limit_q),
		.drive_current     (drive_current),
		.online            (online)
	);

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_offline_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !online |-> drive_current == 16'sd0)
		else $error("offline result carries a nonzero drive current");

	a_online_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(feedback_seen))
		else $error("online flag dropped without reset");

	a_online_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(feedback_seen) |-> $past(v_s1 && !operation_s1))
		else $error("online flag set without a feedback beat");

	a_tick_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && operation_s1 && v_s2 && !go2 |-> !in_ready)
		else $error("input taken while a tick is stuck in the input register");
`endif

endmodule

`default_nettype wire
